// ===== design/msr_pkg.sv =====
// Package for the modular square root block: widths, constants, sequencer states.
// No dependencies.
package msr_pkg;
  localparam int unsigned WIDTH = 64;
  localparam int unsigned PW = 63;
  localparam int unsigned NONRES_LIMIT = 4096;
  localparam logic [PW-1:0] PRIME_RESET = 63'd3;

  typedef enum logic [4:0] {
    MM_IDLE = 5'b00001,
    MM_RUN  = 5'b00010,
    MM_DONE = 5'b00100,
    MM_RSV0 = 5'b01000,
    MM_RSV1 = 5'b10000
  } mm_state_e;

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_RED    = 16'h0002,
    S_PRE    = 16'h0004,
    S_POW    = 16'h0008,
    S_POWW   = 16'h0010,
    S_EUL    = 16'h0020,
    S_NRS    = 16'h0040,
    S_TSA    = 16'h0080,
    S_TSB    = 16'h0100,
    S_TSC    = 16'h0200,
    S_SQ     = 16'h0400,
    S_SQW    = 16'h0800,
    S_BSQ    = 16'h1000,
    S_UPD    = 16'h2000,
    S_MMW    = 16'h4000,
    S_OUT    = 16'h8000
  } seq_state_e;

  // what the running exponentiation is for
  typedef enum logic [2:0] {
    P_EUL = 3'd0,
    P_R34 = 3'd1,
    P_NRS = 3'd2,
    P_C   = 3'd3,
    P_X   = 3'd4,
    P_T   = 3'd5
  } pow_sel_e;

  typedef struct packed {
    logic          start;
    logic [PW-1:0] x;
    logic [PW-1:0] y;
    logic [PW-1:0] p;
  } mm_req_t;

  typedef struct packed {
    logic          done;
    logic [PW-1:0] r;
  } mm_rsp_t;
endpackage

// ===== design/msr_if.sv =====
// Valid/ready channel interfaces for the modular square root block.
// Depends on msr_pkg.
interface msr_in_if import msr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] a_value;
  modport source (output valid, output a_value, input ready);
  modport sink (input valid, input a_value, output ready);
endinterface

interface msr_out_if import msr_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [PW-1:0] root;
  logic          has_root;
  modport source (output valid, output root, output has_root, input ready);
  modport sink (input valid, input root, input has_root, output ready);
endinterface

// ===== design/msr_mulmod.sv =====
// Bit-serial modular multiplier: one double-and-add step per cycle, 63 steps.
// Depends on msr_pkg.
module msr_mulmod import msr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  mm_req_t req_i,
  output mm_rsp_t rsp_o
);
  mm_state_e     state_q, state_d;
  logic [PW-1:0] acc_q, acc_d, x_q, y_q, p_q;
  logic [5:0]    bit_q, bit_d;
  logic [PW:0]   dbl, dbr, ad, adr;

  always_comb begin
    dbl = {acc_q, 1'b0};
    dbr = (dbl >= {1'b0, p_q}) ? dbl - {1'b0, p_q} : dbl;
    ad  = dbr + {1'b0, x_q};
    adr = (ad >= {1'b0, p_q}) ? ad - {1'b0, p_q} : ad;
    state_d = state_q;
    acc_d = acc_q;
    bit_d = bit_q;
    case (state_q)
      MM_IDLE, MM_DONE: begin
        if (req_i.start) begin
          state_d = MM_RUN;
          acc_d = '0;
          bit_d = 6'd62;
        end else state_d = MM_IDLE;
      end
      MM_RUN: begin
        acc_d = y_q[bit_q] ? adr[PW-1:0] : dbr[PW-1:0];
        if (bit_q == 6'd0) state_d = MM_DONE;
        else bit_d = bit_q - 6'd1;
      end
      default: state_d = MM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    bit_q <= bit_d;
    if (req_i.start && (state_q != MM_RUN)) begin
      x_q <= req_i.x;
      y_q <= req_i.y;
      p_q <= req_i.p;
    end
  end

  assign rsp_o.done = (state_q == MM_DONE);
  assign rsp_o.r    = acc_q;

`ifndef SYNTHESIS
  a_res_lt_p: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == MM_DONE) && (p_q != '0) |-> acc_q < p_q) else $error("mulmod result not reduced");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == MM_DONE) |=> state_q != MM_DONE || $past(req_i.start)) else $error("done repeats");
  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == MM_RUN) && (bit_q == 6'd0) |=> state_q == MM_DONE) else $error("run overran");
`endif
endmodule

// ===== design/msr_divu.sv =====
// Restoring divider (remainder only): 64-bit dividend by 63-bit modulus, one bit per cycle.
// Depends on msr_pkg.
module msr_divu import msr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] num_i,
  input  logic [PW-1:0]    den_i,
  output logic             done_o,
  output logic [PW-1:0]    rem_o
);
  logic             busy_q, done_q;
  logic [WIDTH-1:0] num_q;
  logic [PW:0]      rem_q, sh;
  logic [PW-1:0]    den_q;
  logic [6:0]       cnt_q;

  assign sh = {rem_q[PW-1:0], num_q[WIDTH-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == 7'd1) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      cnt_q <= 7'(WIDTH);
    end else if (busy_q) begin
      num_q <= {num_q[WIDTH-2:0], 1'b0};
      rem_q <= (sh >= {1'b0, den_q}) ? sh - {1'b0, den_q} : sh;
      cnt_q <= cnt_q - 7'd1;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[PW-1:0];
endmodule

// ===== design/modular_square_root.sv =====
// Modular square root modulo a configured prime (Tonelli-Shanks), one shared multiplier.
// A zero value, a modulus of two and any other even modulus are settled right after the reduction,
// with no exponentiation; a modulus below two skips the divider too. Exponentiation by e uses
// square-and-multiply on the shared multiplier, one exponent bit after another, low bit first.
// Throughput: one item at a time, in ready only while idle; a held result stalls the next load.
// Reset: asynchronous active low; modulus returns to 3, no memories to clear.
module modular_square_root import msr_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [PW-1:0] cfg_wdata_i,
  msr_in_if.sink        in_if,
  msr_out_if.source     out_if
);
  seq_state_e    st_q, ret_q;
  pow_sel_e      pw_q;
  logic [PW-1:0] p_q, a_q, q_q, z_q, c_q, x_q, t_q, y_q, b_q, e_q, base_q, r_q, res_q;
  logic [PW-1:0] oroot_q;
  logic [5:0]    s_q, m_q, i_q, k_q;
  logic          ok_q, neg_q, bsel_q, ohas_q;
  logic          ovalid_q, out_load, pow_mr;
  logic [WIDTH-1:0] mag;
  logic          div_start, div_done;
  logic [PW-1:0] div_rem;
  mm_req_t       mreq;
  mm_rsp_t       mrsp;
  logic [PW-1:0] mx, my;
  logic          mstart;
  logic [PW-1:0] pm1, half;

  assign pm1  = p_q - 63'd1;
  assign half = pm1 >> 1;
  assign mag  = in_if.a_value[WIDTH-1] ? (~in_if.a_value) + 64'd1 : in_if.a_value;

  msr_divu u_div (.clk_i, .rst_ni, .start_i(div_start), .num_i(mag), .den_i(p_q),
    .done_o(div_done), .rem_o(div_rem));

  assign mreq.start = mstart;
  assign mreq.x = mx;
  assign mreq.y = my;
  assign mreq.p = p_q;
  msr_mulmod u_mm (.clk_i, .rst_ni, .req_i(mreq), .rsp_o(mrsp));

  assign in_if.ready = (st_q == S_IDLE);
  assign div_start = in_if.valid && in_if.ready && (p_q >= 63'd2);
  assign out_load  = (st_q == S_OUT) && (!ovalid_q || out_if.ready);

  // bsel_q: the multiply into r for the current exponent bit is done
  assign pow_mr = e_q[0] && !bsel_q;

  always_comb begin
    mstart = 1'b0;
    mx = r_q;
    my = base_q;
    case (st_q)
      S_POW: begin
        mstart = (e_q != '0);
        mx = pow_mr ? r_q : base_q;
        my = base_q;
      end
      S_SQ: begin
        mstart = 1'b1;
        mx = y_q;
        my = y_q;
      end
      S_BSQ: begin
        mstart = 1'b1;
        mx = b_q;
        my = b_q;
      end
      S_UPD: begin
        mstart = 1'b1;
        case (k_q[1:0])
          2'd0: begin mx = x_q; my = b_q; end
          2'd1: begin mx = b_q; my = b_q; end
          default: begin mx = t_q; my = c_q; end
        endcase
      end
      default: mstart = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      ret_q <= S_IDLE;
      pw_q <= P_EUL;
      ovalid_q <= 1'b0;
      p_q <= PRIME_RESET;
      {a_q, q_q, z_q, c_q, x_q, t_q} <= '0;
      {y_q, b_q, e_q, base_q, r_q, res_q, oroot_q} <= '0;
      {s_q, m_q, i_q, k_q} <= '0;
      {ok_q, neg_q, bsel_q, ohas_q} <= '0;
    end else begin
      if (cfg_we_i) p_q <= cfg_wdata_i;
      if (out_load) ovalid_q <= 1'b1;
      else if (out_if.ready) ovalid_q <= 1'b0;
      case (st_q)
        S_IDLE: if (in_if.valid && in_if.ready) begin
          neg_q <= in_if.a_value[WIDTH-1];
          if (p_q < 63'd2) begin
            ok_q <= 1'b0;
            res_q <= '0;
            st_q <= S_OUT;
          end else st_q <= S_RED;
        end
        S_RED: if (div_done) begin
          a_q <= (neg_q && div_rem != '0) ? p_q - div_rem : div_rem;
          st_q <= S_PRE;
        end
        S_PRE: begin
          if (a_q == '0 || p_q == 63'd2) begin
            res_q <= a_q;
            ok_q <= 1'b1;
            st_q <= S_OUT;
          end else begin
            res_q <= '0;
            ok_q <= 1'b0;
            if (!p_q[0]) begin
              st_q <= S_OUT;
            end else begin
              pw_q <= P_EUL;
              base_q <= a_q;
              e_q <= half;
              r_q <= 63'd1;
              bsel_q <= 1'b0;
              st_q <= S_POW;
              ret_q <= S_EUL;
              q_q <= pm1;
              s_q <= '0;
            end
          end
        end
        // square-and-multiply, low bit first: r *= b on a set bit, then b *= b
        S_POW: begin
          if (e_q == '0) st_q <= ret_q;
          else st_q <= S_POWW;
        end
        S_POWW: if (mrsp.done) begin
          if (pow_mr) begin
            r_q <= mrsp.r;
            bsel_q <= 1'b1;
          end else begin
            base_q <= mrsp.r;
            e_q <= e_q >> 1;
            bsel_q <= 1'b0;
          end
          st_q <= S_POW;
        end
        S_EUL: begin
          case (pw_q)
            P_EUL: begin
              if (r_q != 63'd1) st_q <= S_OUT;
              else if (q_q[0]) begin
                if (s_q == 6'd1) begin
                  pw_q <= P_R34;
                  base_q <= a_q;
                  e_q <= (p_q >> 2) + 63'd1;
                  r_q <= 63'd1;
                  bsel_q <= 1'b0;
                  ret_q <= S_EUL;
                  st_q <= S_POW;
                end else begin
                  z_q <= 63'd2;
                  st_q <= S_NRS;
                end
              end else begin
                q_q <= q_q >> 1;
                s_q <= s_q + 6'd1;
              end
            end
            P_R34: begin
              res_q <= r_q;
              ok_q <= 1'b1;
              st_q <= S_OUT;
            end
            P_NRS: begin
              if (r_q == pm1) begin
                pw_q <= P_C;
                base_q <= z_q;
                e_q <= q_q;
                r_q <= 63'd1;
                bsel_q <= 1'b0;
                st_q <= S_POW;
              end else begin
                z_q <= z_q + 63'd1;
                st_q <= S_NRS;
              end
            end
            P_C: begin
              c_q <= r_q;
              pw_q <= P_X;
              base_q <= a_q;
              e_q <= (q_q >> 1) + 63'd1;
              r_q <= 63'd1;
              bsel_q <= 1'b0;
              st_q <= S_POW;
            end
            P_X: begin
              x_q <= r_q;
              pw_q <= P_T;
              base_q <= a_q;
              e_q <= q_q;
              r_q <= 63'd1;
              bsel_q <= 1'b0;
              st_q <= S_POW;
            end
            default: begin
              t_q <= r_q;
              m_q <= s_q;
              st_q <= S_TSA;
            end
          endcase
        end
        S_NRS: begin
          if (z_q >= p_q || z_q >= 63'(NONRES_LIMIT)) st_q <= S_OUT;
          else begin
            pw_q <= P_NRS;
            base_q <= z_q;
            e_q <= half;
            r_q <= 63'd1;
            bsel_q <= 1'b0;
            ret_q <= S_EUL;
            st_q <= S_POW;
          end
        end
        S_TSA: begin
          if (t_q == 63'd1) begin
            res_q <= x_q;
            ok_q <= 1'b1;
            st_q <= S_OUT;
          end else begin
            i_q <= 6'd1;
            y_q <= t_q;
            ret_q <= S_TSB;
            st_q <= S_SQ;
          end
        end
        S_SQ: st_q <= S_SQW;
        S_SQW: if (mrsp.done) begin
          y_q <= mrsp.r;
          st_q <= ret_q;
        end
        S_TSB: begin
          if (y_q != 63'd1 && i_q < m_q) begin
            i_q <= i_q + 6'd1;
            st_q <= S_SQ;
          end else if (y_q != 63'd1) begin
            st_q <= S_OUT;
          end else begin
            b_q <= c_q;
            k_q <= '0;
            st_q <= S_TSC;
          end
        end
        S_TSC: begin
          if (k_q + i_q + 6'd1 < m_q) st_q <= S_BSQ;
          else begin
            k_q <= '0;
            ret_q <= S_UPD;
            st_q <= S_UPD;
          end
        end
        S_BSQ: st_q <= S_MMW;
        S_UPD: st_q <= S_MMW;
        S_MMW: if (mrsp.done) begin
          if (ret_q != S_UPD) begin
            b_q <= mrsp.r;
            if (k_q + i_q + 6'd2 < m_q) begin
              k_q <= k_q + 6'd1;
              st_q <= S_BSQ;
            end else begin
              k_q <= '0;
              ret_q <= S_UPD;
              st_q <= S_UPD;
            end
          end else begin
            case (k_q[1:0])
              2'd0: x_q <= mrsp.r;
              2'd1: c_q <= mrsp.r;
              default: t_q <= mrsp.r;
            endcase
            if (k_q[1:0] == 2'd2) begin
              m_q <= i_q;
              ret_q <= S_IDLE;
              st_q <= S_TSA;
            end else begin
              k_q <= k_q + 6'd1;
              st_q <= S_UPD;
            end
          end
        end
        S_OUT: if (out_load) begin
          oroot_q <= ok_q ? res_q : '0;
          ohas_q <= ok_q;
          st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid    = ovalid_q;
  assign out_if.root     = oroot_q;
  assign out_if.has_root = ohas_q;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_IDLE) |-> !in_if.ready) else $error("ready while busy");
  a_root_lt_p: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.has_root && (p_q != '0) |-> out_if.root < p_q)
    else $error("root not reduced");
  a_red_lt_p: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_PRE) |-> a_q < p_q) else $error("reduction out of range");
`endif
endmodule
